FILE: rtl/hgtb_pkg.sv
package hgtb_pkg;

   localparam int REQ_W   = 80;
   localparam int RSP_W   = 16;
   localparam int CSR_A_W = 8;
   localparam int CSR_D_W = 24;

   localparam int LIMIT_W = 46;
   localparam int COST_W  = 38;
   localparam int HALF_W  = 23;
   localparam int PART_W  = 47;
   localparam int PROD_W  = 70;

   localparam logic [29:0] TOKEN_SCALE  = 30'd1000000000;
   localparam logic [3:0]  MAX_ATTEMPTS = 4'd8;

   localparam logic [7:0]  TTL_GUESS_LOW  = 8'd64;
   localparam logic [7:0]  TTL_GUESS_MID  = 8'd128;
   localparam logic [7:0]  TTL_GUESS_HIGH = 8'd255;
   // x / 100 == (x * 5243) >> 19 for x below 43690
   localparam logic [12:0] PCT_RECIP       = 13'd5243;
   localparam int          PCT_RECIP_SHIFT = 19;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   localparam logic [CSR_A_W-1:0] CSR_BURST_SIZE      = 8'd0;
   localparam logic [CSR_A_W-1:0] CSR_REFILL_RATE     = 8'd1;
   localparam logic [CSR_A_W-1:0] CSR_REPEAT_COUNT    = 8'd2;
   localparam logic [CSR_A_W-1:0] CSR_BASE_TTL        = 8'd3;
   localparam logic [CSR_A_W-1:0] CSR_ESTIMATE_ENABLE = 8'd4;
   localparam logic [CSR_A_W-1:0] CSR_HOP_PERCENT     = 8'd5;

   typedef enum logic [1:0] {
      VERDICT_GRANTED = 2'd0,
      VERDICT_SKIPPED = 2'd1,
      VERDICT_LIMITED = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOAD,
      BK_MUL_LO,
      BK_MUL_HI,
      BK_SUM,
      BK_CAP,
      BK_CHARGE,
      BK_EMIT
   } back_state_type;

   typedef struct packed {
      logic [15:0] burst_size;
      logic [23:0] refill_rate;
      logic [7:0]  repeat_count;
      logic [7:0]  base_ttl;
      logic        estimate_enable;
      logic [7:0]  hop_percent;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic [63:0] now;
      logic        skipped;
      logic [7:0]  probe_ttl;
      logic        ttl_unknown;
   } job_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] tokens;
      logic [63:0]        last;
   } bucket_type;

endpackage

FILE: rtl/hgtb_front.sv
module hgtb_front (
   input  logic                          clock,
   input  logic                          reset,
   input  hgtb_pkg::cfg_type             cfg,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [hgtb_pkg::REQ_W-1:0]    req_tdata,
   output logic                          push_valid,
   input  logic                          push_ready,
   output hgtb_pkg::job_type             push_job
);

   logic        s1_valid_ff, s1_valid_in;
   logic [3:0]  slot_ff;
   logic [63:0] now_ff;
   logic        unknown_ff;
   logic        est_ff;
   logic [7:0]  hops_ff;
   logic [15:0] scaled_ff;

   logic        req_fire;
   logic [7:0]  peer;
   logic [7:0]  guess_ttl;
   logic [7:0]  hops;
   logic [28:0] recip;
   logic [8:0]  dyn;
   logic [8:0]  ttl_wide;
   logic        skip;

   assign req_fire  = req_tvalid & req_tready;
   assign peer      = req_tdata[75:68];
   assign guess_ttl = (peer <= hgtb_pkg::TTL_GUESS_LOW) ? hgtb_pkg::TTL_GUESS_LOW :
                      (peer <= hgtb_pkg::TTL_GUESS_MID) ? hgtb_pkg::TTL_GUESS_MID :
                                                           hgtb_pkg::TTL_GUESS_HIGH;
   assign hops      = guess_ttl - peer;

   assign req_tready  = ~s1_valid_ff | push_ready;
   assign s1_valid_in = req_fire | (s1_valid_ff & ~push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         slot_ff    <= req_tdata[3:0];
         now_ff     <= req_tdata[67:4];
         unknown_ff <= (peer == 8'd0);
         est_ff     <= cfg.estimate_enable & (peer != 8'd0);
         hops_ff    <= hops;
         scaled_ff  <= 16'(hops) * 16'(cfg.hop_percent);
      end
   end

   // divide by 100 through the reciprocal
   assign recip    = 29'(scaled_ff) * 29'(hgtb_pkg::PCT_RECIP);
   assign dyn      = recip[hgtb_pkg::PCT_RECIP_SHIFT +: 9];
   assign ttl_wide = (est_ff && (dyn > {1'b0, cfg.base_ttl})) ? dyn : {1'b0, cfg.base_ttl};
   assign skip     = est_ff & (ttl_wide >= {1'b0, hops_ff});

   assign push_valid           = s1_valid_ff;
   assign push_job.slot        = slot_ff;
   assign push_job.now         = now_ff;
   assign push_job.skipped     = skip;
   assign push_job.probe_ttl   = ttl_wide[8] ? 8'hFF : ttl_wide[7:0];
   assign push_job.ttl_unknown = unknown_ff;

endmodule

FILE: rtl/hgtb_queue.sv
module hgtb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hgtb_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output hgtb_pkg::job_type pop_job
);

   localparam int PTR_W = hgtb_pkg::QUEUE_PTR_W;
   localparam int DEPTH = hgtb_pkg::QUEUE_DEPTH;

   hgtb_pkg::job_type entries_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push_fire, pop_fire;

   assign push_ready = (count_ff != (PTR_W + 1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign push_fire  = push_valid & push_ready;
   assign pop_fire   = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: rtl/hgtb_back.sv
module hgtb_back #(
   parameter int BUCKET_SLOTS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  hgtb_pkg::cfg_type          cfg,
   input  logic                       pop_valid,
   output logic                       pop_ready,
   input  hgtb_pkg::job_type          pop_job,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [hgtb_pkg::RSP_W-1:0] rsp_tdata
);

   localparam int SLOT_AW = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
   localparam int LW = hgtb_pkg::LIMIT_W;
   localparam int CW = hgtb_pkg::COST_W;
   localparam int HW = hgtb_pkg::HALF_W;
   localparam int PW = hgtb_pkg::PART_W;
   localparam int QW = hgtb_pkg::PROD_W;

   hgtb_pkg::back_state_type state_ff, state_in;

   hgtb_pkg::bucket_type bucket_mem_ff [BUCKET_SLOTS];
   logic                 slot_valid_ff [BUCKET_SLOTS];

   hgtb_pkg::job_type    job_ff;
   hgtb_pkg::bucket_type rd_ff;
   logic                 rd_valid_ff;
   logic [SLOT_AW-1:0]   idx_ff;
   logic [LW-1:0]        limit_ff;
   logic [CW-1:0]        cost_ff;
   logic [LW-1:0]        tokens_ff;
   logic [LW-1:0]        elapsed_ff;
   logic                 far_ff;
   logic [PW-1:0]        lo_ff, hi_ff;
   logic [QW-1:0]        prod_ff;
   logic [LW-1:0]        level_ff;
   hgtb_pkg::verdict_type verdict_ff;
   logic [3:0]           attempts_ff;
   logic                 rsp_valid_ff;
   logic [hgtb_pkg::RSP_W-1:0] rsp_data_ff;

   logic               in_range;
   logic [SLOT_AW-1:0] pop_idx;
   logic               mem_wr;
   logic               rsp_load;
   logic [LW-1:0]      cur_tokens;
   logic [63:0]        cur_last;
   logic [63:0]        elapsed;
   logic               full;
   logic [LW:0]        sum;
   logic               grant;
   logic [3:0]         attempts_cap;
   hgtb_pkg::bucket_type wr_entry;

   assign in_range = (32'(pop_job.slot) < 32'(BUCKET_SLOTS));
   assign pop_idx  = SLOT_AW'(pop_job.slot);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hgtb_pkg::BK_IDLE: begin
            if (pop_valid) begin
               state_in = (pop_job.skipped || !in_range) ? hgtb_pkg::BK_EMIT
                                                         : hgtb_pkg::BK_LOAD;
            end
         end
         hgtb_pkg::BK_LOAD:   state_in = hgtb_pkg::BK_MUL_LO;
         hgtb_pkg::BK_MUL_LO: state_in = hgtb_pkg::BK_MUL_HI;
         hgtb_pkg::BK_MUL_HI: state_in = hgtb_pkg::BK_SUM;
         hgtb_pkg::BK_SUM:    state_in = hgtb_pkg::BK_CAP;
         hgtb_pkg::BK_CAP:    state_in = hgtb_pkg::BK_CHARGE;
         hgtb_pkg::BK_CHARGE: state_in = hgtb_pkg::BK_EMIT;
         hgtb_pkg::BK_EMIT: begin
            if (rsp_load) begin
               state_in = hgtb_pkg::BK_IDLE;
            end
         end
         default: state_in = hgtb_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      pop_ready = (state_ff == hgtb_pkg::BK_IDLE);
      mem_wr    = (state_ff == hgtb_pkg::BK_CHARGE);
      rsp_load  = (state_ff == hgtb_pkg::BK_EMIT) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hgtb_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // bucket state; an entry without its valid bit reads as full and never used
   always_comb begin
      cur_tokens = rd_valid_ff ? rd_ff.tokens : '0;
      cur_last   = rd_valid_ff ? rd_ff.last   : '0;
      if (cur_last == 64'd0) begin
         cur_tokens = limit_ff;
         cur_last   = job_ff.now;
      end
      elapsed = job_ff.now - cur_last;
   end

   assign full = (cfg.refill_rate == '0) || far_ff || (prod_ff > QW'(limit_ff));
   assign sum  = (LW + 1)'(tokens_ff) + (LW + 1)'(prod_ff[LW-1:0]);

   assign grant        = (level_ff >= LW'(cost_ff));
   assign attempts_cap = (cfg.repeat_count < 8'(hgtb_pkg::MAX_ATTEMPTS)) ?
                         cfg.repeat_count[3:0] : hgtb_pkg::MAX_ATTEMPTS;
   assign wr_entry.tokens = grant ? (level_ff - LW'(cost_ff)) : level_ff;
   assign wr_entry.last   = job_ff.now;

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         bucket_mem_ff[idx_ff] <= wr_entry;
      end
      if (pop_valid && pop_ready) begin
         rd_ff <= bucket_mem_ff[pop_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUCKET_SLOTS; i++) begin
            slot_valid_ff[i] <= 1'b0;
         end
      end else if (mem_wr) begin
         slot_valid_ff[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         hgtb_pkg::BK_IDLE: begin
            if (pop_valid) begin
               job_ff      <= pop_job;
               idx_ff      <= pop_idx;
               rd_valid_ff <= slot_valid_ff[pop_idx];
               limit_ff    <= LW'(cfg.burst_size) * LW'(hgtb_pkg::TOKEN_SCALE);
               verdict_ff  <= pop_job.skipped ? hgtb_pkg::VERDICT_SKIPPED
                                              : hgtb_pkg::VERDICT_LIMITED;
               attempts_ff <= 4'd0;
            end
         end
         hgtb_pkg::BK_LOAD: begin
            tokens_ff  <= cur_tokens;
            elapsed_ff <= elapsed[LW-1:0];
            far_ff     <= (elapsed[63:LW] != '0);
            cost_ff    <= CW'(cfg.repeat_count) * CW'(hgtb_pkg::TOKEN_SCALE);
         end
         hgtb_pkg::BK_MUL_LO: begin
            lo_ff <= PW'(elapsed_ff[HW-1:0]) * PW'(cfg.refill_rate);
         end
         hgtb_pkg::BK_MUL_HI: begin
            hi_ff <= PW'(elapsed_ff[LW-1:HW]) * PW'(cfg.refill_rate);
         end
         hgtb_pkg::BK_SUM: begin
            prod_ff <= QW'(lo_ff) + {hi_ff, {HW{1'b0}}};
         end
         hgtb_pkg::BK_CAP: begin
            level_ff <= (full || (sum > (LW + 1)'(limit_ff))) ? limit_ff : sum[LW-1:0];
         end
         hgtb_pkg::BK_CHARGE: begin
            verdict_ff  <= grant ? hgtb_pkg::VERDICT_GRANTED : hgtb_pkg::VERDICT_LIMITED;
            attempts_ff <= grant ? attempts_cap : 4'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, job_ff.ttl_unknown, attempts_ff, job_ff.probe_ttl, verdict_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/hop_gated_token_bucket.sv
// A bucket request passes the front register, the queue and back states LOAD, MUL_LO,
//   MUL_HI, SUM, CAP, CHARGE and EMIT; a skipped request or one for a slot with no
//   bucket goes from IDLE to EMIT (plus any output stall). The back end takes no new
//   request until the last is emitted (RMW sequencer, split 46x24 refill multiply).
// Reset clears configuration to defaults, the request queue and all bucket valid bits;
//   buckets read as full and never used at once, with no clearing pass.
module hop_gated_token_bucket #(
   parameter int BUCKET_SLOTS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [3:0] bucket_slot, [67:4] now_ns, [75:68] peer_ttl, [79:76] zero
   input  logic [hgtb_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [1:0] verdict, [9:2] probe_ttl, [13:10] attempt_count, [14] ttl_unknown, [15] zero
   output logic [hgtb_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hgtb_pkg::CSR_A_W-1:0] csr_index,
   input  logic [hgtb_pkg::CSR_D_W-1:0] csr_data
);

   hgtb_pkg::cfg_type cfg_ff;
   logic              push_valid, push_ready;
   hgtb_pkg::job_type push_job;
   logic              pop_valid, pop_ready;
   hgtb_pkg::job_type pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.burst_size      <= 16'd8;
         cfg_ff.refill_rate     <= 24'd1;
         cfg_ff.repeat_count    <= 8'd1;
         cfg_ff.base_ttl        <= 8'd1;
         cfg_ff.estimate_enable <= 1'b0;
         cfg_ff.hop_percent     <= 8'd50;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            hgtb_pkg::CSR_BURST_SIZE:      cfg_ff.burst_size      <= csr_data[15:0];
            hgtb_pkg::CSR_REFILL_RATE:     cfg_ff.refill_rate     <= csr_data[23:0];
            hgtb_pkg::CSR_REPEAT_COUNT:    cfg_ff.repeat_count    <= csr_data[7:0];
            hgtb_pkg::CSR_BASE_TTL:        cfg_ff.base_ttl        <= csr_data[7:0];
            hgtb_pkg::CSR_ESTIMATE_ENABLE: cfg_ff.estimate_enable <= csr_data[0];
            hgtb_pkg::CSR_HOP_PERCENT:     cfg_ff.hop_percent     <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   hgtb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   hgtb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   hgtb_back #(
      .BUCKET_SLOTS (BUCKET_SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
